// File: src/psgrsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psgrsd_pkg;

	localparam int REGS_PER_CHIP = 14;
	localparam int NUM_AMP       = 6;
	localparam int AMP_PER_CHIP  = 3;
	localparam int NUM_SLOTS     = 7;
	localparam int FRAME_SLOT    = NUM_SLOTS - 1;

	localparam logic [7:0] FLAG_MASK0 = 8'h01;
	localparam logic [7:0] FLAG_MASK1 = 8'h02;
	localparam logic [7:0] FLAG_HOLD  = 8'h04;
	localparam logic [7:0] FLAG_DELTA = 8'h08;
	localparam logic [7:0] END_MARK   = 8'hFF;
	localparam int         CONT_BIT   = 7;
	localparam int         ENV_BIT    = 4;
	localparam logic [7:0] AMP_MAX    = 8'd15;
	localparam logic [3:0] AMP_REG0   = 4'd8;
	localparam logic [3:0] AMP_REG2   = 4'd10;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ATTEN  = 2'd0;
	localparam logic [1:0] CFG_CHIPS  = 2'd1;
	localparam logic [1:0] CFG_LOOP   = 2'd2;

	// Delta codes.
	localparam logic [1:0] DELTA_NONE  = 2'd0;
	localparam logic [1:0] DELTA_DEC1  = 2'd1;
	localparam logic [1:0] DELTA_DEC2  = 2'd2;
	localparam logic [1:0] DELTA_INC1  = 2'd3;

	typedef enum logic [1:0] {
		KIND_WRITE      = 2'd0,
		KIND_FRAME_END  = 2'd1,
		KIND_STREAM_END = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic       chip;
		logic [3:0] reg_idx;
		logic [7:0] value;
		logic [7:0] hold;
		logic       restart;
	} result_t;

	// Register number for each position of a mask byte pair.
	function automatic logic [3:0] reg_of_pos(input logic [3:0] pos);
		logic [3:0] r;
		unique case (pos)
			4'd0:    r = 4'd8;
			4'd1:    r = 4'd9;
			4'd2:    r = 4'd10;
			4'd3:    r = 4'd7;
			4'd4:    r = 4'd0;
			4'd5:    r = 4'd2;
			4'd6:    r = 4'd4;
			4'd7:    r = 4'd1;
			4'd8:    r = 4'd3;
			4'd9:    r = 4'd5;
			4'd10:   r = 4'd6;
			4'd11:   r = 4'd11;
			4'd12:   r = 4'd12;
			4'd13:   r = 4'd13;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	// Amplitudes without the envelope bit are lowered by the attenuation, floored at zero.
	function automatic logic [7:0] attenuate(input logic [7:0] v, input logic [3:0] att);
		logic [7:0] r;
		if (v[ENV_BIT]) begin
			r = v;
		end else if (v > {4'd0, att}) begin
			r = v - {4'd0, att};
		end else begin
			r = 8'd0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: src/psg_register_stream_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// A stream word is captured in the input register, and its results are then loaded into
// the result burst register, from which they leave lowest slot first.
// Throughput: one stream word per cycle while each word yields at most one result and
// m_tready stays high; a word with more results (up to seven) holds the next word until its last one leaves.
// Reset (arst_n low) clears the parser and amplitude shadows and returns the
// configuration to its defaults at once.
module psg_register_stream_decoder_core
	import psgrsd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [23:0] m_tdata,   // [0] chip_select, [4:1] reg_index, [12:5] reg_value,
	                                    // [20:13] hold_frames, [21] restart, [23:22] zero
	output      logic [1:0]  m_tuser,   // [1:0] result_kind
	output      logic        m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [3:0]  cfg_data
);

	typedef enum logic [3:0] {
		PH_CTRL = 4'd0,
		PH_DLO  = 4'd1,
		PH_DHI  = 4'd2,
		PH_M0   = 4'd3,
		PH_M0HI = 4'd4,
		PH_M1   = 4'd5,
		PH_M1HI = 4'd6,
		PH_HOLD = 4'd7,
		PH_V0   = 4'd8,
		PH_V1   = 4'd9
	} phase_t;

	function automatic phase_t next_phase(input phase_t from, input logic [7:0] flags,
	                                      input logic [13:0] m0, input logic [13:0] m1);
		phase_t p;
		if (from <= PH_DLO && (flags & FLAG_DELTA) != 8'd0) begin
			p = PH_DLO;
		end else if (from <= PH_M0 && (flags & FLAG_MASK0) != 8'd0) begin
			p = PH_M0;
		end else if (from <= PH_M1 && (flags & FLAG_MASK1) != 8'd0) begin
			p = PH_M1;
		end else if (from <= PH_HOLD && (flags & FLAG_HOLD) != 8'd0) begin
			p = PH_HOLD;
		end else if (from <= PH_V0 && m0 != 14'd0) begin
			p = PH_V0;
		end else if (from <= PH_V1 && m1 != 14'd0) begin
			p = PH_V1;
		end else begin
			p = PH_CTRL;
		end
		return p;
	endfunction

	// Configuration
	logic [3:0] atten_q;
	logic [1:0] chips_q;
	logic       loop_q;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Parser state
	phase_t      phase_q, phase_d;
	logic [7:0]  flags_q, flags_d;
	logic [7:0]  dlo_q, dlo_d;
	logic [13:0] m0_q, m0_d;
	logic [13:0] m1_q, m1_d;
	logic [7:0]  hold_q, hold_d;
	logic [7:0]  shadow_q [NUM_AMP];
	logic [7:0]  shadow_d [NUM_AMP];
	logic        jr_q, jr_d;
	logic        stopped_q, stopped_d;

	// Result burst: one slot per possible result, emitted lowest slot first
	result_t               slot_q [NUM_SLOTS];
	result_t               slot_d [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]  mask_q, mask_d;
	logic [NUM_SLOTS-1:0]  head_oh;
	logic [2:0]            head_idx;
	result_t               head;

	logic        advance;
	logic        second_ok;
	logic        is_end;
	logic [7:0]  amp_new [NUM_AMP];
	logic [1:0]  amp_code [NUM_AMP];
	logic        val_chip;
	logic [13:0] val_mask;
	logic [3:0]  val_pos;
	logic [3:0]  val_reg;
	logic [2:0]  val_amp;
	logic        val_is_amp;

	assign second_ok = (chips_q == 2'd2);

	// Output side
	assign head_oh = mask_q & (~mask_q + NUM_SLOTS'(1));

	always_comb begin
		head_idx = '0;
		for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
			if (mask_q[k]) begin
				head_idx = 3'(k);
			end
		end
	end

	assign head     = slot_q[head_idx];
	assign m_tvalid = |mask_q;
	assign m_tlast  = m_tvalid && ((mask_q & ~head_oh) == '0);
	assign m_tuser  = head.kind;
	assign m_tdata  = {2'b00, head.restart, head.hold, head.value, head.reg_idx, head.chip};

	// A new burst loads when the previous one is gone or leaves this cycle.
	assign advance  = valid_s1 && (mask_q == '0 || (m_tready && m_tlast));
	assign s_tready = !valid_s1 || advance;

	// Amplitude deltas, one lane per channel
	always_comb begin
		for (int k = 0; k < NUM_AMP; k++) begin
			amp_code[k] = (k < 4) ? dlo_q[2*(k%4) +: 2] : byte_s1[2*(k%2) +: 2];
			unique case (amp_code[k])
				DELTA_INC1: amp_new[k] = (shadow_q[k] < AMP_MAX) ? shadow_q[k] + 8'd1 : AMP_MAX;
				DELTA_DEC1: amp_new[k] = (shadow_q[k] != 8'd0) ? shadow_q[k] - 8'd1 : 8'd0;
				DELTA_DEC2: amp_new[k] = (shadow_q[k] > 8'd1) ? shadow_q[k] - 8'd2 : 8'd0;
				default:    amp_new[k] = shadow_q[k];
			endcase
		end
	end

	// Value write: lowest pending mask position of the current chip
	assign val_chip = (phase_q == PH_V1);
	assign val_mask = val_chip ? m1_q : m0_q;

	always_comb begin
		val_pos = '0;
		for (int i = REGS_PER_CHIP - 1; i >= 0; i--) begin
			if (val_mask[i]) begin
				val_pos = 4'(i);
			end
		end
	end

	assign val_reg    = reg_of_pos(val_pos);
	assign val_is_amp = (val_reg >= AMP_REG0) && (val_reg <= AMP_REG2);
	assign val_amp    = 3'(val_reg - AMP_REG0) + (val_chip ? 3'(AMP_PER_CHIP) : 3'd0);

	// Parser step for the word in the input register
	always_comb begin
		phase_d   = phase_q;
		flags_d   = flags_q;
		dlo_d     = dlo_q;
		m0_d      = m0_q;
		m1_d      = m1_q;
		hold_d    = hold_q;
		jr_d      = jr_q;
		stopped_d = stopped_q;
		is_end    = 1'b0;
		mask_d    = '0;
		for (int k = 0; k < NUM_AMP; k++) begin
			shadow_d[k] = shadow_q[k];
		end
		for (int k = 0; k < NUM_SLOTS; k++) begin
			slot_d[k] = '0;
		end

		if (!stopped_q) begin
			unique case (phase_q) inside
				PH_DLO: begin
					dlo_d   = byte_s1;
					phase_d = PH_DHI;
				end
				PH_DHI: begin
					for (int k = 0; k < NUM_AMP; k++) begin
						if (amp_code[k] != DELTA_NONE) begin
							shadow_d[k]       = amp_new[k];
							slot_d[k].kind    = KIND_WRITE;
							slot_d[k].chip    = (k >= AMP_PER_CHIP);
							slot_d[k].reg_idx = AMP_REG0 +
								4'((k >= AMP_PER_CHIP) ? k - AMP_PER_CHIP : k);
							slot_d[k].value   = attenuate(amp_new[k], atten_q);
							mask_d[k]         = (k < AMP_PER_CHIP) || second_ok;
						end
					end
					phase_d = next_phase(PH_M0, flags_q, m0_q, m1_q);
				end
				PH_M0: begin
					m0_d    = {7'd0, byte_s1[6:0]};
					phase_d = byte_s1[CONT_BIT] ? PH_M0HI : next_phase(PH_M1, flags_q, m0_d, m1_q);
				end
				PH_M0HI: begin
					m0_d    = m0_q | {byte_s1[6:0], 7'd0};
					phase_d = next_phase(PH_M1, flags_q, m0_d, m1_q);
				end
				PH_M1: begin
					m1_d    = {7'd0, byte_s1[6:0]};
					phase_d = byte_s1[CONT_BIT] ? PH_M1HI : next_phase(PH_HOLD, flags_q, m0_q, m1_d);
				end
				PH_M1HI: begin
					m1_d    = m1_q | {byte_s1[6:0], 7'd0};
					phase_d = next_phase(PH_HOLD, flags_q, m0_q, m1_d);
				end
				PH_HOLD: begin
					hold_d  = byte_s1;
					phase_d = next_phase(PH_V0, flags_q, m0_q, m1_q);
				end
				PH_V0, PH_V1: begin
					if (val_is_amp) begin
						shadow_d[val_amp] = byte_s1;
					end
					slot_d[0].kind    = KIND_WRITE;
					slot_d[0].chip    = val_chip;
					slot_d[0].reg_idx = val_reg;
					slot_d[0].value   = val_is_amp ? attenuate(byte_s1, atten_q) : byte_s1;
					mask_d[0]         = !val_chip || second_ok;
					if (val_chip) begin
						m1_d    = m1_q & ~(14'd1 << val_pos);
						phase_d = next_phase(PH_V1, flags_q, m0_q, m1_d);
					end else begin
						m0_d    = m0_q & ~(14'd1 << val_pos);
						phase_d = next_phase(PH_V0, flags_q, m0_d, m1_q);
					end
				end
				default: begin
					if (byte_s1 == END_MARK) begin
						is_end         = 1'b1;
						slot_d[0].kind = KIND_STREAM_END;
						mask_d[0]      = 1'b1;
						if (loop_q && !jr_q) begin
							slot_d[0].restart = 1'b1;
							jr_d              = 1'b1;
						end else begin
							stopped_d = 1'b1;
							jr_d      = 1'b0;
						end
						phase_d = PH_CTRL;
					end else begin
						jr_d    = 1'b0;
						flags_d = byte_s1;
						m0_d    = '0;
						m1_d    = '0;
						hold_d  = '0;
						phase_d = next_phase(PH_DLO, byte_s1, 14'd0, 14'd0);
					end
				end
			endcase

			if (!is_end && phase_d == PH_CTRL) begin
				slot_d[FRAME_SLOT].kind = KIND_FRAME_END;
				slot_d[FRAME_SLOT].hold = hold_d;
				mask_d[FRAME_SLOT]      = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atten_q   <= '0;
			chips_q   <= 2'd2;
			loop_q    <= 1'b0;
			valid_s1  <= 1'b0;
			phase_q   <= PH_CTRL;
			flags_q   <= '0;
			dlo_q     <= '0;
			m0_q      <= '0;
			m1_q      <= '0;
			hold_q    <= '0;
			jr_q      <= 1'b0;
			stopped_q <= 1'b0;
			mask_q    <= '0;
			for (int k = 0; k < NUM_AMP; k++) begin
				shadow_q[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ATTEN: atten_q <= cfg_data;
					CFG_CHIPS: chips_q <= cfg_data[1:0];
					CFG_LOOP:  loop_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				phase_q   <= phase_d;
				flags_q   <= flags_d;
				dlo_q     <= dlo_d;
				m0_q      <= m0_d;
				m1_q      <= m1_d;
				hold_q    <= hold_d;
				jr_q      <= jr_d;
				stopped_q <= stopped_d;
				mask_q    <= mask_d;
				for (int k = 0; k < NUM_AMP; k++) begin
					shadow_q[k] <= shadow_d[k];
				end
			end else if (m_tvalid && m_tready) begin
				mask_q <= mask_q & ~head_oh;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
		if (advance) begin
			for (int k = 0; k < NUM_SLOTS; k++) begin
				slot_q[k] <= slot_d[k];
			end
		end
	end

	// A stream end is always the only result of its word.
	a_stream_end_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_STREAM_END) |-> m_tlast)
		else $error("stream end not marked last");

	// A frame end always closes the burst of its word.
	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_FRAME_END) |-> m_tlast)
		else $error("frame end not marked last");

	// Stopping only happens on an end marker, so the parser sits at a control word.
	a_stop_at_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> (phase_q == PH_CTRL))
		else $error("stopped inside a frame");

	a_write_reg_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_WRITE) |-> (m_tdata[4:1] <= 4'd13))
		else $error("register write beyond the register file");

endmodule

`default_nettype wire
